@@ hw/rtl/fwsik_pkg.sv @@
// ----------------------------------------------------------------------------
// fwsik_pkg
// Shared types, constants and the arctangent table for the four-wheel
// steering inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package fwsik_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                       CORDIC_ITERATIONS : ATAN_ENTRIES;
    localparam int SQRT_STEPS        = 16;
    localparam int PIPE_STEPS        = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int NUM_WHEELS        = 4;

    localparam int WHL_FL = 0;
    localparam int WHL_RL = 1;
    localparam int WHL_RR = 2;
    localparam int WHL_FR = 3;

    typedef logic signed [42:0] t_vec;   // vector component, scaled by 2^24
    typedef logic signed [28:0] t_ang;   // angle in 2^-24 rad
    typedef logic        [31:0] t_root;  // square root remainder and partial root

    localparam t_ang PI_Q24   = 29'sd52707179;
    localparam t_ang ROUND_HALF = 29'sd2048;

    typedef enum logic [7:0] {
        REG_HALF_WHEELBASE = 8'd0,
        REG_HALF_TRACK     = 8'd1,
        REG_STEER_MIN      = 8'd2,
        REG_STEER_MAX      = 8'd3
    } t_cfg_reg;

    function automatic t_ang atan_q24(input int i);
        t_ang v;
        case (i)
            0:  v = 29'sd13176795;
            1:  v = 29'sd7778716;
            2:  v = 29'sd4110060;
            3:  v = 29'sd2086331;
            4:  v = 29'sd1047214;
            5:  v = 29'sd524117;
            6:  v = 29'sd262123;
            7:  v = 29'sd131069;
            8:  v = 29'sd65536;
            9:  v = 29'sd32768;
            10: v = 29'sd16384;
            11: v = 29'sd8192;
            12: v = 29'sd4096;
            13: v = 29'sd2048;
            14: v = 29'sd1024;
            15: v = 29'sd512;
            16: v = 29'sd256;
            17: v = 29'sd128;
            18: v = 29'sd64;
            19: v = 29'sd32;
            20: v = 29'sd16;
            21: v = 29'sd8;
            22: v = 29'sd4;
            23: v = 29'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/four_wheel_steer_inverse_kinematics.sv @@
// ----------------------------------------------------------------------------
// four_wheel_steer_inverse_kinematics
// Body speed and yaw rate to four signed wheel speeds and clamped steering
// angles: pipelined square root and CORDIC vectoring per wheel.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  command   i_valid / o_ready, i_body_speed, i_yaw_rate  in
//  result    o_valid / i_ready, o_speed_*, o_angle_*   out
//  config    i_cfg_valid / o_cfg_ready, index, data     in
//
//  The 16-step root stages and the CORDIC stages run side by side, after
//  stages A to C and before the output stage.
//  One request is accepted every cycle unless the output stalls. A stall
//  at the output freezes the whole pipeline; the output register holds
//  the waiting result. Synchronous active-low reset clears the valid bits
//  and loads the register defaults.
// ----------------------------------------------------------------------------
module four_wheel_steer_inverse_kinematics (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_body_speed,
    input  logic signed [15:0] i_yaw_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_speed_front_left,
    output logic signed [16:0] o_speed_rear_left,
    output logic signed [16:0] o_speed_rear_right,
    output logic signed [16:0] o_speed_front_right,
    output logic signed [14:0] o_angle_front_left,
    output logic signed [14:0] o_angle_rear_left,
    output logic signed [14:0] o_angle_rear_right,
    output logic signed [14:0] o_angle_front_right,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [7:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);
    import fwsik_pkg::*;

    logic        [9:0]  r_wb;
    logic        [9:0]  r_tr;
    logic signed [14:0] r_lo;
    logic signed [14:0] r_hi;

    logic en;
    assign en          = !o_valid || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= 10'd128;
            r_tr <= 10'd128;
            r_lo <= -15'sd6434;
            r_hi <= 15'sd6434;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_HALF_WHEELBASE: r_wb <= i_cfg_data[9:0];
                REG_HALF_TRACK:     r_tr <= i_cfg_data[9:0];
                REG_STEER_MIN:      r_lo <= i_cfg_data[14:0];
                REG_STEER_MAX:      r_hi <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage A: offset products ----------------
    logic               r_v_a;
    logic signed [15:0] r_a_vx;
    logic signed [26:0] r_a_pw;
    logic signed [26:0] r_a_pl;
    logic signed [26:0] n_a_pw;
    logic signed [26:0] n_a_pl;

    always_comb begin
        n_a_pw = $signed({1'b0, r_tr}) * i_yaw_rate;
        n_a_pl = $signed({1'b0, r_wb}) * i_yaw_rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
        end else if (en) begin
            r_v_a <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_vx <= i_body_speed;
            r_a_pw <= n_a_pw;
            r_a_pl <= n_a_pl;
        end
    end

    // ---------------- stage B: wheel velocity components ----------------
    logic               r_v_b;
    logic signed [16:0] r_b_vx [NUM_WHEELS];
    logic signed [14:0] r_b_vy [NUM_WHEELS];
    logic signed [26:0] pw_neg;
    logic signed [26:0] pl_neg;
    logic signed [26:0] pw_q;
    logic signed [26:0] pwn_q;
    logic signed [26:0] pl_q;
    logic signed [26:0] pln_q;
    logic signed [16:0] vx_a;
    logic signed [16:0] vx_b;

    always_comb begin
        pw_neg = -r_a_pw;
        pl_neg = -r_a_pl;
        pw_q   = r_a_pw >>> 12;
        pwn_q  = pw_neg >>> 12;
        pl_q   = r_a_pl >>> 12;
        pln_q  = pl_neg >>> 12;
        vx_a   = 17'(r_a_vx) - 17'(pw_q);
        vx_b   = 17'(r_a_vx) - 17'(pwn_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_b <= 1'b0;
        end else if (en) begin
            r_v_b <= r_v_a;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_vx[WHL_FL] <= vx_a;
            r_b_vx[WHL_RL] <= vx_a;
            r_b_vx[WHL_RR] <= vx_b;
            r_b_vx[WHL_FR] <= vx_b;
            r_b_vy[WHL_FL] <= pl_q[14:0];
            r_b_vy[WHL_RL] <= pln_q[14:0];
            r_b_vy[WHL_RR] <= pln_q[14:0];
            r_b_vy[WHL_FR] <= pl_q[14:0];
        end
    end

    // ---------------- stage C: squares, CORDIC pre-rotation ----------------
    logic        r_v_c;
    logic [30:0] r_c_sqx [NUM_WHEELS];
    logic [30:0] r_c_sqy [NUM_WHEELS];
    t_vec        r_c_x   [NUM_WHEELS];
    t_vec        r_c_y   [NUM_WHEELS];
    t_ang        r_c_z   [NUM_WHEELS];
    logic        r_c_zero[NUM_WHEELS];
    logic        r_c_neg [NUM_WHEELS];

    logic signed [33:0] sqx [NUM_WHEELS];
    logic signed [30:0] sqy [NUM_WHEELS];
    t_vec               ix  [NUM_WHEELS];
    t_vec               iy  [NUM_WHEELS];
    t_ang               iz  [NUM_WHEELS];

    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            sqx[w] = r_b_vx[w] * r_b_vx[w];
            sqy[w] = r_b_vy[w] * r_b_vy[w];
            ix[w]  = t_vec'(r_b_vx[w]) <<< 24;
            iy[w]  = t_vec'(r_b_vy[w]) <<< 24;
            iz[w]  = '0;
            // turn a left-half vector by pi first
            if (r_b_vx[w] < 0) begin
                iz[w] = (r_b_vy[w] >= 0) ? PI_Q24 : -PI_Q24;
                ix[w] = -ix[w];
                iy[w] = -iy[w];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c <= 1'b0;
        end else if (en) begin
            r_v_c <= r_v_b;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
                r_c_sqx[w]  <= sqx[w][30:0];
                r_c_sqy[w]  <= sqy[w][30:0];
                r_c_x[w]    <= ix[w];
                r_c_y[w]    <= iy[w];
                r_c_z[w]    <= iz[w];
                r_c_zero[w] <= (r_b_vx[w] == '0) && (r_b_vy[w] == '0);
                r_c_neg[w]  <= r_b_vx[w] < 0;
            end
        end
    end

    // ---------------- step stages: root and CORDIC side by side ----------------
    logic  r_v_s  [PIPE_STEPS+1];
    t_root r_s_n  [PIPE_STEPS+1][NUM_WHEELS];
    t_root r_s_r  [PIPE_STEPS+1][NUM_WHEELS];
    t_vec  r_s_x  [PIPE_STEPS+1][NUM_WHEELS];
    t_vec  r_s_y  [PIPE_STEPS+1][NUM_WHEELS];
    t_ang  r_s_z  [PIPE_STEPS+1][NUM_WHEELS];
    logic  r_s_zero[PIPE_STEPS+1][NUM_WHEELS];
    logic  r_s_neg[PIPE_STEPS+1][NUM_WHEELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_s[0] <= 1'b0;
        end else if (en) begin
            r_v_s[0] <= r_v_c;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
                r_s_n[0][w]    <= 32'(r_c_sqx[w]) + 32'(r_c_sqy[w]);
                r_s_r[0][w]    <= '0;
                r_s_x[0][w]    <= r_c_x[w];
                r_s_y[0][w]    <= r_c_y[w];
                r_s_z[0][w]    <= r_c_z[w];
                r_s_zero[0][w] <= r_c_zero[w];
                r_s_neg[0][w]  <= r_c_neg[w];
            end
        end
    end

    for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
        localparam int    SH  = (k < SQRT_STEPS) ? (30 - 2 * k) : 0;
        localparam t_root BIT = t_root'(1) << SH;
        localparam t_ang  ATN = atan_q24(k);

        t_root n_n [NUM_WHEELS];
        t_root n_r [NUM_WHEELS];
        t_vec  n_x [NUM_WHEELS];
        t_vec  n_y [NUM_WHEELS];
        t_ang  n_z [NUM_WHEELS];
        t_vec  xs  [NUM_WHEELS];
        t_vec  ys  [NUM_WHEELS];
        t_root trial [NUM_WHEELS];

        always_comb begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
                n_n[w]   = r_s_n[k][w];
                n_r[w]   = r_s_r[k][w];
                trial[w] = r_s_r[k][w] + BIT;
                if (k < SQRT_STEPS) begin
                    if (r_s_n[k][w] >= trial[w]) begin
                        n_n[w] = r_s_n[k][w] - trial[w];
                        n_r[w] = (r_s_r[k][w] >> 1) + BIT;
                    end else begin
                        n_r[w] = r_s_r[k][w] >> 1;
                    end
                end
                xs[w]  = r_s_x[k][w] >>> k;
                ys[w]  = r_s_y[k][w] >>> k;
                n_x[w] = r_s_x[k][w];
                n_y[w] = r_s_y[k][w];
                n_z[w] = r_s_z[k][w];
                if (k < CORDIC_STEPS) begin
                    if (r_s_y[k][w] >= 0) begin
                        n_x[w] = r_s_x[k][w] + ys[w];
                        n_y[w] = r_s_y[k][w] - xs[w];
                        n_z[w] = r_s_z[k][w] + ATN;
                    end else begin
                        n_x[w] = r_s_x[k][w] - ys[w];
                        n_y[w] = r_s_y[k][w] + xs[w];
                        n_z[w] = r_s_z[k][w] - ATN;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_s[k+1] <= 1'b0;
            end else if (en) begin
                r_v_s[k+1] <= r_v_s[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int w = 0; w < NUM_WHEELS; w++) begin
                    r_s_n[k+1][w]    <= n_n[w];
                    r_s_r[k+1][w]    <= n_r[w];
                    r_s_x[k+1][w]    <= n_x[w];
                    r_s_y[k+1][w]    <= n_y[w];
                    r_s_z[k+1][w]    <= n_z[w];
                    r_s_zero[k+1][w] <= r_s_zero[k][w];
                    r_s_neg[k+1][w]  <= r_s_neg[k][w];
                end
            end
        end
    end

    // ---------------- output stage: sign, rounding, clamp ----------------
    logic               r_v_o;
    logic signed [16:0] r_o_spd [NUM_WHEELS];
    logic signed [14:0] r_o_ang [NUM_WHEELS];
    logic signed [16:0] n_spd   [NUM_WHEELS];
    logic signed [14:0] n_ang   [NUM_WHEELS];
    t_ang               zr      [NUM_WHEELS];
    logic signed [16:0] ar      [NUM_WHEELS];

    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            n_spd[w] = r_s_neg[PIPE_STEPS][w] ? -17'($signed({1'b0, r_s_r[PIPE_STEPS][w][15:0]}))
                                              :  17'($signed({1'b0, r_s_r[PIPE_STEPS][w][15:0]}));
            zr[w] = (r_s_z[PIPE_STEPS][w] + ROUND_HALF) >>> 12;
            ar[w] = r_s_zero[PIPE_STEPS][w] ? '0 : zr[w][16:0];
            // limit to the top first, then raise to the bottom
            if (ar[w] > 17'(r_hi)) begin
                ar[w] = 17'(r_hi);
            end
            if (ar[w] < 17'(r_lo)) begin
                ar[w] = 17'(r_lo);
            end
            n_ang[w] = ar[w][14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_o <= 1'b0;
        end else if (en) begin
            r_v_o <= r_v_s[PIPE_STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
                r_o_spd[w] <= n_spd[w];
                r_o_ang[w] <= n_ang[w];
            end
        end
    end

    assign o_valid             = r_v_o;
    assign o_speed_front_left  = r_o_spd[WHL_FL];
    assign o_speed_rear_left   = r_o_spd[WHL_RL];
    assign o_speed_rear_right  = r_o_spd[WHL_RR];
    assign o_speed_front_right = r_o_spd[WHL_FR];
    assign o_angle_front_left  = r_o_ang[WHL_FL];
    assign o_angle_rear_left   = r_o_ang[WHL_RL];
    assign o_angle_rear_right  = r_o_ang[WHL_RR];
    assign o_angle_front_right = r_o_ang[WHL_FR];

endmodule

@@ tb/sv/four_wheel_steer_inverse_kinematics_tb.sv @@
// ----------------------------------------------------------------------------
// four_wheel_steer_inverse_kinematics_tb
// Drives speed and yaw-rate requests through several steering geometries and
// limit settings, predicts each wheel's speed and angle, and compares every
// result in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_wheel_steer_inverse_kinematics_tb;
    import fwsik_pkg::*;

    typedef struct packed {
        logic signed [16:0] spd_fl, spd_rl, spd_rr, spd_fr;
        logic signed [14:0] ang_fl, ang_rl, ang_rr, ang_fr;
    } t_wheels;

    // Register copies used by the predictor
    logic [9:0]         geo_l  = 10'd128;
    logic [9:0]         geo_w  = 10'd128;
    logic signed [14:0] lim_lo = -15'sd6434;
    logic signed [14:0] lim_hi = 15'sd6434;
    int                 errors = 0;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r = 0;
        longint b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                          262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                          1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    function automatic longint heading(longint y, longint x);
        longint z = 0;
        longint nx, ny;
        int n;
        if (x == 0 && y == 0) return 0;
        x = x * 16777216;
        y = y * 16777216;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
            x = -x;
            y = -y;
        end
        n = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
        for (int i = 0; i < n; i++) begin
            if (y >= 0) begin
                nx = x + fshr(y, i);
                ny = y - fshr(x, i);
                z  = z + longint'(atan_tab(i));
            end else begin
                nx = x - fshr(y, i);
                ny = y + fshr(x, i);
                z  = z - longint'(atan_tab(i));
            end
            x = nx;
            y = ny;
        end
        return fshr(z + 2048, 12);
    endfunction

    function automatic t_wheels wheel_kinematics(logic signed [15:0] vx16,
                                                 logic signed [15:0] om16);
        longint vx, om, vxi, vyi, mag, spd, ang;
        longint xw[4], yw[4];
        logic signed [16:0] s[4];
        logic signed [14:0] a[4];
        t_wheels w;
        vx = vx16;
        om = om16;
        xw = '{longint'(geo_l), -longint'(geo_l), -longint'(geo_l), longint'(geo_l)};
        yw = '{longint'(geo_w), longint'(geo_w), -longint'(geo_w), -longint'(geo_w)};
        for (int k = 0; k < 4; k++) begin
            vxi = vx - fshr(yw[k] * om, 12);
            vyi = fshr(xw[k] * om, 12);
            mag = root_floor(vxi * vxi + vyi * vyi);
            spd = (vxi < 0) ? -mag : mag;
            ang = heading(vyi, vxi);
            if (spd > 65535) spd = 65535;
            if (spd < -65536) spd = -65536;
            if (ang > longint'(lim_hi)) ang = lim_hi;
            if (ang < longint'(lim_lo)) ang = lim_lo;
            s[k] = spd[16:0];
            a[k] = ang[14:0];
        end
        w.spd_fl = s[WHL_FL]; w.spd_rl = s[WHL_RL];
        w.spd_rr = s[WHL_RR]; w.spd_fr = s[WHL_FR];
        w.ang_fl = a[WHL_FL]; w.ang_rl = a[WHL_RL];
        w.ang_rr = a[WHL_RR]; w.ang_fr = a[WHL_FR];
        return w;
    endfunction

    class wheel_scoreboard;
        t_wheels pending[$];
        int      fails = 0;

        function void note_request(t_wheels w);
            pending = {pending, w};
        endfunction

        function void cmp(string nm, longint e, longint a);
            if (e != a) begin
                $display("%0t %s mismatch: expected %0d actual %0d", $time, nm, e, a);
                fails++;
            end
        endfunction

        function void check_result(t_wheels got);
            t_wheels exp_w;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                fails++;
                return;
            end
            exp_w = pending.pop_front();
            cmp("speed_front_left",  exp_w.spd_fl, got.spd_fl);
            cmp("speed_rear_left",   exp_w.spd_rl, got.spd_rl);
            cmp("speed_rear_right",  exp_w.spd_rr, got.spd_rr);
            cmp("speed_front_right", exp_w.spd_fr, got.spd_fr);
            cmp("angle_front_left",  exp_w.ang_fl, got.ang_fl);
            cmp("angle_rear_left",   exp_w.ang_rl, got.ang_rl);
            cmp("angle_rear_right",  exp_w.ang_rr, got.ang_rr);
            cmp("angle_front_right", exp_w.ang_fr, got.ang_fr);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_body_speed = '0;
    logic signed [15:0] i_yaw_rate = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [16:0] o_speed_front_left, o_speed_rear_left;
    logic signed [16:0] o_speed_rear_right, o_speed_front_right;
    logic signed [14:0] o_angle_front_left, o_angle_rear_left;
    logic signed [14:0] o_angle_rear_right, o_angle_front_right;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    wheel_scoreboard sb = new();
    logic            stall_on = 1'b0;
    int              idle_cycles = 0;

    four_wheel_steer_inverse_kinematics uut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result side: check on rising edge, vary ready on falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result('{o_speed_front_left, o_speed_rear_left, o_speed_rear_right,
                              o_speed_front_right, o_angle_front_left, o_angle_rear_left,
                              o_angle_rear_right, o_angle_front_right});
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 2000) begin
            $display("four_wheel_steer_inverse_kinematics regression: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!stall_on) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 31) != 0 ||
                       $urandom_range(0, 1) != 0);
        end
    end

    task automatic send_cmd(logic signed [15:0] vx, logic signed [15:0] om);
        i_body_speed <= vx;
        i_yaw_rate   <= om;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(wheel_kinematics(vx, om));
        @(negedge i_clk);
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    // Leaves the write channel valid; configure drops it after the last write
    task automatic write_reg(t_cfg_reg idx, logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_HALF_WHEELBASE: geo_l  = val[9:0];
            REG_HALF_TRACK:     geo_w  = val[9:0];
            REG_STEER_MIN:      lim_lo = val[14:0];
            REG_STEER_MAX:      lim_hi = val[14:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (PIPE_STEPS + 10) @(negedge i_clk);
    endtask

    task automatic configure(int l, int w, int lo, int hi);
        write_reg(REG_HALF_WHEELBASE, 16'(l));
        write_reg(REG_HALF_TRACK, 16'(w));
        write_reg(REG_STEER_MIN, 16'(lo));
        write_reg(REG_STEER_MAX, 16'(hi));
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic in bursts with gaps
    task automatic random_phase(int n);
        int left = n;
        int burst, gap;
        logic signed [15:0] vx, om;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && left > 0; b++) begin
                case ($urandom_range(0, 5))
                    0: begin vx = 16'($urandom); om = 16'($urandom); end
                    1: begin vx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                             om = 16'($urandom); end
                    2: begin vx = '0; om = 16'($urandom); end
                    3: begin vx = 16'($urandom); om = '0; end
                    default: begin
                        vx = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
                        om = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
                    end
                endcase
                send_cmd(vx, om);
                left--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                drop_valid();
                repeat (gap) @(negedge i_clk);
            end
        end
        drop_valid();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset geometry, field extremes, zero vector, reverse
        send_cmd(0, 0);
        send_cmd(16'sh7fff, 0);
        send_cmd(16'sh8000, 0);
        send_cmd(0, 16'sh7fff);
        send_cmd(0, 16'sh8000);
        send_cmd(16'sh7fff, 16'sh7fff);
        send_cmd(16'sh8000, 16'sh8000);
        send_cmd(16'sh8000, 16'sh7fff);
        send_cmd(-16'sd256, 16'sd4096);
        send_cmd(16'sd256, -16'sd4096);
        send_cmd(16'shffff, 16'shffff);
        drop_valid();
        drain();

        // Largest geometry, widest limits
        configure(1023, 1023, -12868, 12868);
        send_cmd(16'sh7fff, 16'sh7fff);
        send_cmd(16'sh8000, 16'sh7fff);
        send_cmd(16'sh8000, 16'sh8000);
        send_cmd(0, 16'sh8000);
        drop_valid();
        drain();

        // Zero geometry and inverted limits
        configure(0, 0, 1000, -1000);
        send_cmd(-16'sd5, 16'sd300);
        send_cmd(16'sd5, 16'sd300);
        send_cmd(0, 16'sh7fff);
        drop_valid();
        drain();

        // Limits beyond the nominal range are taken as written
        configure(512, 0, -16384, 16383);
        send_cmd(-16'sd1, 16'sh7fff);
        send_cmd(-16'sd1, 16'sh8000);
        drop_valid();
        drain();

        stall_on = 1'b1;
        configure(128, 128, -6434, 6434);
        random_phase(400);
        drain();
        configure($urandom_range(0, 1023), $urandom_range(0, 1023),
                  -$urandom_range(0, 12868), $urandom_range(0, 12868));
        random_phase(300);
        drain();
        configure($urandom_range(0, 1023), 1023, 12868, -12868);
        random_phase(150);
        drain();
        configure(0, $urandom_range(0, 1023), -12868, 12868);
        random_phase(150);
        drain();

        if (sb.fails == 0) begin
            $display("four_wheel_steer_inverse_kinematics regression: pass");
        end else begin
            $display("four_wheel_steer_inverse_kinematics regression: fail");
        end
        $finish;
    end

endmodule
